/* design/usb_interrupt_interval_patcher_core_macros.svh */
// Assertion macros used by the interval patcher top level.
`ifndef USB_INTERRUPT_INTERVAL_PATCHER_CORE_MACROS_SVH
`define USB_INTERRUPT_INTERVAL_PATCHER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define UIIP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property on every rising edge, reset included.
`define UIIP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define UIIP_ASSERT(label, clk, rst, prop, msg)
`define UIIP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* design/uiip_pkg.sv */
// Types, constants and helper functions for the interval patcher.
`timescale 1ns / 1ps
package uiip_pkg;

   localparam logic [7:0] DescTypeEndpoint = 8'd5;
   localparam logic [1:0] XferInterrupt    = 2'd3;
   localparam logic [7:0] TypeOffset       = 8'd1;
   localparam logic [7:0] AttrOffset       = 8'd3;
   localparam logic [7:0] IntervalOffset   = 8'd6;
   localparam logic [7:0] MinPatchLength   = 8'd7;
   localparam logic [7:0] MaxPow2Interval  = 8'd32;

   localparam logic OverrideIndex = 1'b0;

   // One result beat.
   typedef struct packed {
      logic [7:0] patched_byte;
      logic       end_of_blob;
      logic       structure_ok;
   } rsp_beat_type;

   // Walker status seen by the top level.
   typedef struct packed {
      logic at_start;
      logic malformed;
   } walk_status_type;

   // Largest power of two not above v, capped at 32; zero stays zero.
   function automatic logic [7:0] round_down_pow2(input logic [7:0] v);
      logic [7:0] r;
      begin
         if (v >= MaxPow2Interval) r = MaxPow2Interval;
         else if (v[4])            r = 8'd16;
         else if (v[3])            r = 8'd8;
         else if (v[2])            r = 8'd4;
         else if (v[1])            r = 8'd2;
         else if (v[0])            r = 8'd1;
         else                      r = 8'd0;
         return r;
      end
   endfunction

endpackage

/* design/uiip_csr.sv */
// APB-style register file holding the interval override.
`timescale 1ns / 1ps
module uiip_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [7:0]  override_interval
);

   logic [7:0] override_ff;
   logic [7:0] override_in;
   logic       hit;

   assign hit = (paddr[2] == uiip_pkg::OverrideIndex);

   // Write on the access phase of a write beat.
   always_comb begin
      override_in = override_ff;
      if (psel && penable && pwrite && hit) begin
         override_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         override_ff <= 8'd0;
      end else begin
         override_ff <= override_in;
      end
   end

   // Read back; misses return zero.
   assign prdata            = hit ? {24'd0, override_ff} : 32'd0;
   assign pready            = 1'b1;
   assign override_interval = override_ff;

endmodule

/* design/uiip_walker.sv */
// Descriptor chain walker: tracks offsets and rewrites the interval byte.
`timescale 1ns / 1ps
module uiip_walker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [7:0]                  data_byte,
   input  logic                        final_byte,
   input  logic [7:0]                  override_interval,
   output uiip_pkg::rsp_beat_type      beat,
   output uiip_pkg::walk_status_type   status
);

   logic [7:0] offset_ff,   offset_in;
   logic [7:0] length_ff,   length_in;
   logic       endpoint_ff, endpoint_in;
   logic       interrupt_ff, interrupt_in;
   logic       malformed_ff, malformed_in;

   logic       at_start;
   logic [7:0] len_eff;
   logic [8:0] off_next;
   logic       patch_hit;
   logic [7:0] new_interval;

   assign at_start = (offset_ff == 8'd0);
   assign len_eff  = at_start ? data_byte : length_ff;
   assign off_next = {1'b0, offset_ff} + 9'd1;

   // Pick the replacement interval.
   always_comb begin
      if (data_byte == 8'd0) begin
         new_interval = 8'd0;
      end else if (override_interval != 8'd0) begin
         new_interval = override_interval;
      end else begin
         new_interval = uiip_pkg::round_down_pow2(data_byte);
      end
   end

   assign patch_hit = (offset_ff == uiip_pkg::IntervalOffset) && !malformed_ff &&
                      endpoint_ff && interrupt_ff &&
                      (length_ff >= uiip_pkg::MinPatchLength);

   // Build the result beat.
   always_comb begin
      beat.patched_byte = patch_hit ? new_interval : data_byte;
      beat.end_of_blob  = final_byte;
      beat.structure_ok = final_byte && !malformed_ff && !at_start &&
                          (off_next == {1'b0, length_ff});
   end

   // Advance the walk state on each accepted beat.
   always_comb begin
      offset_in    = offset_ff;
      length_in    = length_ff;
      endpoint_in  = endpoint_ff;
      interrupt_in = interrupt_ff;
      malformed_in = malformed_ff;
      if (accept) begin
         if (at_start) begin
            length_in    = data_byte;
            endpoint_in  = 1'b0;
            interrupt_in = 1'b0;
            if (data_byte == 8'd0) begin
               malformed_in = 1'b1;
            end
         end else if (offset_ff == uiip_pkg::TypeOffset) begin
            endpoint_in = (data_byte == uiip_pkg::DescTypeEndpoint);
         end else if (offset_ff == uiip_pkg::AttrOffset) begin
            interrupt_in = (data_byte[1:0] == uiip_pkg::XferInterrupt);
         end
         if (final_byte) begin
            offset_in    = 8'd0;
            length_in    = 8'd0;
            endpoint_in  = 1'b0;
            interrupt_in = 1'b0;
            malformed_in = 1'b0;
         end else if (off_next >= {1'b0, len_eff}) begin
            offset_in = 8'd0;
         end else begin
            offset_in = off_next[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= 8'd0;
         length_ff    <= 8'd0;
         endpoint_ff  <= 1'b0;
         interrupt_ff <= 1'b0;
         malformed_ff <= 1'b0;
      end else begin
         offset_ff    <= offset_in;
         length_ff    <= length_in;
         endpoint_ff  <= endpoint_in;
         interrupt_ff <= interrupt_in;
         malformed_ff <= malformed_in;
      end
   end

   assign status.at_start  = at_start;
   assign status.malformed = malformed_ff;

endmodule

/* design/uiip_out_stage.sv */
// Result register: holds one beat until the consumer takes it.
`timescale 1ns / 1ps
module uiip_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  uiip_pkg::rsp_beat_type in_beat,
   output logic                   out_valid,
   input  logic                   out_ready,
   output uiip_pkg::rsp_beat_type out_beat
);

   logic                   valid_ff, valid_in;
   uiip_pkg::rsp_beat_type beat_ff, beat_in;
   logic                   load;

   // Take a new beat when empty or while the held one drains.
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (load) begin
         valid_in = 1'b1;
         beat_in  = in_beat;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

/* design/usb_interrupt_interval_patcher_core.sv */
// Top level of the USB interrupt interval patcher.
//
//   port group   dir   beat contents
//   req_*        in    data_byte, final_byte
//   rsp_*        out   patched_byte, end_of_blob, structure_ok
//   APB          in    override_interval at byte address 0
//
// One byte per cycle unless the result register stalls; each result appears in the cycle after
// its byte is taken, held in the single result register after the walker logic.
// Reset clears the walk state, the override register and the result valid flag.
// A stalled result holds in the result register; req_ready drops only while it
// is full and rsp_ready is low. After a last byte the walk restarts cleanly.
`timescale 1ns / 1ps
`include "usb_interrupt_interval_patcher_core_macros.svh"
module usb_interrupt_interval_patcher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_patched_byte,
   output logic        rsp_end_of_blob,
   output logic        rsp_structure_ok,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic                       accept;
   logic [7:0]                 override_interval;
   uiip_pkg::rsp_beat_type     walk_beat;
   uiip_pkg::rsp_beat_type     out_beat;
   uiip_pkg::walk_status_type  walk_status;
   logic                       ok_off_end;
   logic                       end_taken;
   logic                       walk_fresh;

   assign accept = req_valid && req_ready;

   // Configuration registers.
   uiip_csr u_csr (
      .clock             (clock),
      .reset             (reset),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready),
      .override_interval (override_interval)
   );

   // Walk the chain and patch.
   uiip_walker u_walker (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .data_byte         (req_data_byte),
      .final_byte        (req_final_byte),
      .override_interval (override_interval),
      .beat              (walk_beat),
      .status            (walk_status)
   );

   // Register the result.
   uiip_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_beat   (walk_beat),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_beat  (out_beat)
   );

   assign rsp_patched_byte = out_beat.patched_byte;
   assign rsp_end_of_blob  = out_beat.end_of_blob;
   assign rsp_structure_ok = out_beat.structure_ok;

   // Terms for the checks below.
   assign ok_off_end = rsp_valid && rsp_structure_ok && !rsp_end_of_blob;
   assign end_taken  = accept && req_final_byte;
   assign walk_fresh = walk_status.at_start && !walk_status.malformed;

   // Every taken byte shows up as a result beat next cycle.
   `UIIP_ASSERT(a_accept_gives_beat, clock, reset, accept |=> rsp_valid, "byte lost")
   // Status only ever rides on the last beat.
   `UIIP_ASSERT(a_ok_only_at_end, clock, reset, !ok_off_end, "status off end")
   // A last byte returns the walker to a fresh descriptor start.
   `UIIP_ASSERT(a_end_restarts, clock, reset, end_taken |=> walk_fresh, "walk not cleared")

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the USB interrupt interval patcher core.
`timescale 1ns / 1ps
module testbench;

   localparam logic [2:0] OverrideAddr = {uiip_pkg::OverrideIndex, 2'b00};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_final_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_patched_byte;
   logic        rsp_end_of_blob;
   logic        rsp_structure_ok;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   // Predicted walk state and register copy
   logic [7:0]  walk_offset = 8'd0;
   logic [7:0]  walk_length = 8'd0;
   logic        walk_endpoint = 1'b0;
   logic        walk_interrupt = 1'b0;
   logic        walk_malformed = 1'b0;
   logic [7:0]  interval_setting = 8'd0;

   uiip_pkg::rsp_beat_type expected_beats[$];
   logic [7:0]   blob_bytes[$];
   int           error_count = 0;
   int           beats_sent = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           stall_cycles = 0;
   int           stall_token = 0;
   int           stall_seen = 0;
   int           stall_left = 0;

   usb_interrupt_interval_patcher_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_final_byte   (req_final_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_patched_byte (rsp_patched_byte),
      .rsp_end_of_blob  (rsp_end_of_blob),
      .rsp_structure_ok (rsp_structure_ok),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("usb_interrupt_interval_patcher_core test failed");
      $finish;
   end

   // Largest power of two not above v, capped at the maximum interval
   function automatic logic [7:0] floor_pow2(input logic [7:0] v);
      logic [7:0] r;
      logic [7:0] c;
      r = 8'd0;
      for (c = 8'd1; c != 8'd0 && c <= uiip_pkg::MaxPow2Interval; c = c << 1)
         if (c <= v) r = c;
      return r;
   endfunction

   // Advance the predicted walk by one byte and return the expected beat
   function automatic uiip_pkg::rsp_beat_type walk_descriptor_byte(input logic [7:0] b,
                                                                   input logic last);
      uiip_pkg::rsp_beat_type r;
      logic [7:0]   off;
      logic [8:0]   nxt;
      off = walk_offset;
      r.patched_byte = b;
      r.end_of_blob = last;
      r.structure_ok = 1'b0;
      if (off == 8'd0) begin
         walk_length = b;
         walk_endpoint = 1'b0;
         walk_interrupt = 1'b0;
         if (b == 8'd0) walk_malformed = 1'b1;
      end else if (off == uiip_pkg::TypeOffset) begin
         walk_endpoint = (b == uiip_pkg::DescTypeEndpoint);
      end else if (off == uiip_pkg::AttrOffset) begin
         walk_interrupt = (b[1:0] == uiip_pkg::XferInterrupt);
      end else if (off == uiip_pkg::IntervalOffset) begin
         if (!walk_malformed && walk_endpoint && walk_interrupt &&
             walk_length >= uiip_pkg::MinPatchLength && b != 8'd0)
            r.patched_byte = (interval_setting != 8'd0) ? interval_setting : floor_pow2(b);
      end
      nxt = {1'b0, off} + 9'd1;
      if (last) begin
         // well formed only when this byte closes a descriptor
         r.structure_ok = !walk_malformed && off != 8'd0 && nxt == {1'b0, walk_length};
         walk_offset = 8'd0;
         walk_length = 8'd0;
         walk_endpoint = 1'b0;
         walk_interrupt = 1'b0;
         walk_malformed = 1'b0;
      end else begin
         walk_offset = (nxt >= {1'b0, walk_length}) ? 8'd0 : nxt[7:0];
      end
      return r;
   endfunction

   // Predict on each accepted byte, check each result beat
   always @(posedge clock) begin : check_results
      uiip_pkg::rsp_beat_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_beats.push_back(walk_descriptor_byte(req_data_byte, req_final_byte));
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected result beat: byte %h eob %b ok %b",
                           rsp_patched_byte, rsp_end_of_blob, rsp_structure_ok);
            end else begin
               want = expected_beats.pop_front();
               if (want.patched_byte !== rsp_patched_byte ||
                   want.end_of_blob !== rsp_end_of_blob ||
                   want.structure_ok !== rsp_structure_ok) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("mismatch: expected byte %h eob %b ok %b, got %h %b %b",
                              want.patched_byte, want.end_of_blob, want.structure_ok,
                              rsp_patched_byte, rsp_end_of_blob, rsp_structure_ok);
               end
            end
         end
      end
   end

   // Drive result ready: random idling, or a counted hold-off on request
   always @(posedge clock) begin
      if (stall_token != stall_seen) begin
         stall_seen <= stall_token;
         stall_left <= stall_cycles;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one byte, optionally after a gap, and hold it until accepted
   task automatic send_beat(input logic [7:0] b, input logic last);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_final_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
   endtask

   // Send the staged blob, flagging its last byte
   task automatic send_blob();
      for (int i = 0; i < blob_bytes.size(); i++)
         send_beat(blob_bytes[i], i == blob_bytes.size() - 1);
      blob_bytes.delete();
   endtask

   // Drop valid and wait until every expected beat has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle until pready
   task automatic csr_write(input logic [2:0] addr, input logic [7:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= {24'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == OverrideAddr) interval_setting = value;
   endtask

   // Stage one descriptor; a zero length is a lone byte
   function automatic void add_descriptor(input int len, input logic [7:0] desc_type,
                                          input logic [7:0] attr);
      logic [7:0] b;
      blob_bytes.push_back(len[7:0]);
      for (int i = 1; i < len; i++) begin
         if (i == uiip_pkg::TypeOffset) b = desc_type;
         else if (i == uiip_pkg::AttrOffset) b = attr;
         else if (i == uiip_pkg::IntervalOffset)
            b = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(40));
         else b = 8'($urandom_range(255));
         blob_bytes.push_back(b);
      end
   endfunction

   // Build and send one blob: mostly descriptor chains, some noise and cut tails
   task automatic send_random_blob();
      int         n_desc;
      int         pick;
      int         len;
      logic [7:0] attr;
      n_desc = $urandom_range(1, 4);
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 10)) blob_bytes.push_back(8'($urandom_range(255)));
      end else begin
         for (int d = 0; d < n_desc; d++) begin
            pick = $urandom_range(99);
            attr = 8'($urandom_range(255));
            if (pick < 55) begin
               len = ($urandom_range(3) == 0) ? $urandom_range(8, 12) :
                                                int'(uiip_pkg::MinPatchLength);
               add_descriptor(len, uiip_pkg::DescTypeEndpoint,
                              {attr[7:2], uiip_pkg::XferInterrupt});
            end else if (pick < 70) begin
               add_descriptor($urandom_range(4, 9), uiip_pkg::DescTypeEndpoint, attr);
            end else if (pick < 95) begin
               add_descriptor($urandom_range(1, 12), 8'($urandom_range(255)), attr);
            end else begin
               add_descriptor(0, 8'd0, 8'd0);
            end
         end
         // cut the tail now and then so a descriptor runs past the end
         if (blob_bytes.size() > 1 && $urandom_range(9) == 0)
            repeat ($urandom_range(1, blob_bytes.size() - 1)) void'(blob_bytes.pop_back());
      end
      send_blob();
   endtask

   // Hand-picked blobs: rounding, zero length, lone length byte, overrun, short
   task automatic test_directed_walk();
      blob_bytes = '{8'd2, 8'd9, 8'd7, 8'd5, 8'h81, 8'd3, 8'd8, 8'd0, 8'd33};
      send_blob();
      blob_bytes = '{8'd0};
      send_blob();
      blob_bytes = '{8'd1};
      send_blob();
      blob_bytes = '{8'd0, 8'd7, 8'd5, 8'd0, 8'd3, 8'd0, 8'd0, 8'd9};
      send_blob();
      blob_bytes = '{8'd9, 8'd5, 8'd0, 8'hFF, 8'd0, 8'd0, 8'd0};
      send_blob();
      blob_bytes = '{8'd6, 8'd5, 8'd0, 8'd3, 8'd0, 8'd0};
      send_blob();
   endtask

   // Forced interval at both ends of its range
   task automatic test_override_extremes();
      wait_idle();
      csr_write(OverrideAddr, 8'd255);
      blob_bytes = '{8'd7, 8'd5, 8'd0, 8'd3, 8'd0, 8'd0, 8'd0,
                     8'd7, 8'd5, 8'd0, 8'd3, 8'd0, 8'd0, 8'd1};
      send_blob();
      wait_idle();
      csr_write(OverrideAddr, 8'd1);
      blob_bytes = '{8'd7, 8'd5, 8'd0, 8'd3, 8'd0, 8'd0, 8'd200};
      send_blob();
   endtask

   // Random blobs under one idling profile and one interval setting
   task automatic test_random_phase(input int sender_pct, input int receiver_pct,
                                    input logic [7:0] forced_interval, input int n_beats);
      int stop_at;
      wait_idle();
      csr_write(OverrideAddr, forced_interval);
      send_idle_pct = sender_pct;
      recv_idle_pct <= receiver_pct;
      stop_at = beats_sent + n_beats;
      while (beats_sent < stop_at) send_random_blob();
   endtask

   // Hold the receiver off while bytes keep coming so the input stalls
   task automatic test_backpressure();
      int stop_at;
      wait_idle();
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      stall_cycles <= 60;
      stall_token <= stall_token + 1;
      stop_at = beats_sent + 24;
      while (beats_sent < stop_at) send_random_blob();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_walk();
      test_override_extremes();
      test_random_phase(33, 50, 8'd0, 470);
      test_random_phase(50, 33, 8'($urandom_range(1, 255)), 470);
      test_backpressure();
      test_random_phase(0, 0, 8'd0, 440);
      wait_idle();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("usb_interrupt_interval_patcher_core test passed");
      else
         $display("usb_interrupt_interval_patcher_core test failed");
      $finish;
   end

endmodule

/* sim.f */
+incdir+design
design/uiip_pkg.sv
design/uiip_csr.sv
design/uiip_walker.sv
design/uiip_out_stage.sv
design/usb_interrupt_interval_patcher_core.sv
tb/sv/testbench.sv
